// ----- rtl/pidc_pkg.sv -----
// ---------------------------------------------------------------------------
// pidc_pkg
// shared constants and types for the conditional-integral pid core
// ---------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int FRAC_BITS         = 16;
  localparam int CFG_IDX_W         = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_VALUE = 3'd0,
    REG_GAIN_PROP    = 3'd1,
    REG_GAIN_INTEG   = 3'd2,
    REG_GAIN_DERIV   = 3'd3,
    REG_DRIVE_MIN    = 3'd4,
    REG_DRIVE_MAX    = 3'd5,
    REG_INTEG_WINDOW = 3'd6,
    REG_PLANT_BIAS   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic integ_ok;
    logic ring_full;
  } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/pidc_front.sv -----
// ---------------------------------------------------------------------------
// pidc_front
// input register, sample history ring and error / difference stage
// ---------------------------------------------------------------------------
`default_nettype none

module pidc_front
  import pidc_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [VALUE_WIDTH-1:0] in_sample,
  input  wire logic                          in_enable,
  input  wire logic signed [VALUE_WIDTH-1:0] in_offset,
  input  wire logic                          in_strobe,
  input  wire logic signed [VALUE_WIDTH-1:0] target_value,
  input  wire logic [VALUE_WIDTH-2:0]        integ_window,
  output logic                               s2_valid,
  input  wire logic                          s2_ready_dn,
  output logic signed [VALUE_WIDTH-1:0]      s2_err,
  output logic signed [VALUE_WIDTH-1:0]      s2_perr,
  output logic signed [VALUE_WIDTH-1:0]      s2_diff,
  output ctl_t                               s2_ctl
);

  localparam int W      = VALUE_WIDTH;
  localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] add_sat(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? VMIN : VMAX;
    end
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sub_sat(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? VMIN : VMAX;
    end
    return s[W-1:0];
  endfunction

  logic signed [W-1:0] ring_mem [HISTORY_DEPTH];
  logic [PTR_W-1:0]    wptr_r, wptr_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;

  logic                s1_valid_r;
  logic signed [W-1:0] s1_sample_r;
  logic signed [W-1:0] s1_offset_r;
  logic                s1_enable_r;
  logic                s1_full_r;
  logic signed [W-1:0] s1_oldest_r;

  logic                s2_valid_r;
  logic signed [W-1:0] s2_err_r, s2_err_nxt;
  logic signed [W-1:0] s2_perr_r, s2_perr_nxt;
  logic signed [W-1:0] s2_diff_r, s2_diff_nxt;
  ctl_t                s2_ctl_r, s2_ctl_nxt;
  logic [W-1:0]        err_abs;

  logic s2_ready, s1_ready, accept, s1_move;

  assign s2_ready = !s2_valid_r || s2_ready_dn;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign accept   = in_valid && s1_ready;
  assign s1_move  = s1_valid_r && s2_ready;
  assign in_ready = s1_ready;

  // history ring pointers
  always_comb begin
    wptr_nxt = wptr_r;
    fill_nxt = fill_r;
    if (accept && in_strobe) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
      if (fill_r != FILL_FULL) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r     <= '0;
      fill_r     <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      wptr_r <= wptr_nxt;
      fill_r <= fill_nxt;
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // ring read of the oldest entry happens before the push at the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_oldest_r <= ring_mem[wptr_r];
      if (in_strobe) begin
        ring_mem[wptr_r] <= in_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r <= in_sample;
      s1_offset_r <= in_offset;
      s1_enable_r <= in_enable;
      s1_full_r   <= (fill_r == FILL_FULL);
    end
  end

  always_comb begin
    s2_err_nxt  = sub_sat(target_value, s1_sample_r);
    s2_perr_nxt = add_sat(s2_err_nxt, s1_offset_r);
    s2_diff_nxt = sub_sat(s1_oldest_r, s1_sample_r);
    err_abs     = s2_err_nxt[W-1] ? (~s2_err_nxt + 1'b1) : s2_err_nxt;
    s2_ctl_nxt.integ_ok  = s1_enable_r && (err_abs < {1'b0, integ_window});
    s2_ctl_nxt.ring_full = s1_full_r;
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_err_r  <= s2_err_nxt;
      s2_perr_r <= s2_perr_nxt;
      s2_diff_r <= s2_diff_nxt;
      s2_ctl_r  <= s2_ctl_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_err   = s2_err_r;
  assign s2_perr  = s2_perr_r;
  assign s2_diff  = s2_diff_r;
  assign s2_ctl   = s2_ctl_r;

endmodule

`default_nettype wire

// ----- rtl/pidc_mul.sv -----
// ---------------------------------------------------------------------------
// pidc_mul
// gain multipliers: raw product stage, then q16.16 scaling and saturation
// ---------------------------------------------------------------------------
`default_nettype none

module pidc_mul
  import pidc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          s2_valid,
  output logic                               s2_ready_dn,
  input  wire logic signed [VALUE_WIDTH-1:0] s2_err,
  input  wire logic signed [VALUE_WIDTH-1:0] s2_perr,
  input  wire logic signed [VALUE_WIDTH-1:0] s2_diff,
  input  wire ctl_t                          s2_ctl,
  input  wire logic signed [VALUE_WIDTH-1:0] gain_prop,
  input  wire logic signed [VALUE_WIDTH-1:0] gain_integ,
  input  wire logic signed [VALUE_WIDTH-1:0] gain_deriv,
  output logic                               s4_valid,
  input  wire logic                          s4_ready_dn,
  output logic signed [VALUE_WIDTH-1:0]      s4_p,
  output logic signed [VALUE_WIDTH-1:0]      s4_iinc,
  output logic signed [VALUE_WIDTH-1:0]      s4_d,
  output ctl_t                               s4_ctl
);

  localparam int W  = VALUE_WIDTH;
  localparam int PW = 2 * VALUE_WIDTH;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] MAG_MAX = {{(W+1){1'b0}}, {(W-1){1'b1}}};

  // magnitude truncated toward zero, then sign applied and saturated
  function automatic logic signed [W-1:0] q_scale(input logic signed [PW-1:0] prod);
    logic          neg;
    logic [PW-1:0] mag;
    logic [PW-1:0] sh;
    neg = prod[PW-1];
    mag = neg ? (~prod + 1'b1) : prod;
    sh  = mag >> FRAC_BITS;
    if (neg) begin
      if (sh > MAG_MAX + 1'b1) begin
        return VMIN;
      end
      return ~sh[W-1:0] + 1'b1;
    end
    if (sh > MAG_MAX) begin
      return VMAX;
    end
    return sh[W-1:0];
  endfunction

  logic                 s3_valid_r;
  logic signed [PW-1:0] s3_prod_p_r, s3_prod_i_r, s3_prod_d_r;
  ctl_t                 s3_ctl_r;

  logic                 s4_valid_r;
  logic signed [W-1:0]  s4_p_r, s4_iinc_r, s4_d_r;
  ctl_t                 s4_ctl_r;

  logic s3_ready, s4_ready;

  assign s4_ready    = !s4_valid_r || s4_ready_dn;
  assign s3_ready    = !s3_valid_r || s4_ready;
  assign s2_ready_dn = s3_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_r <= s2_valid;
      end
      if (s4_ready) begin
        s4_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s3_ready) begin
      s3_prod_p_r <= s2_perr * gain_prop;
      s3_prod_i_r <= gain_integ * s2_err;
      s3_prod_d_r <= gain_deriv * s2_diff;
      s3_ctl_r    <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid_r && s4_ready) begin
      s4_p_r    <= q_scale(s3_prod_p_r);
      s4_iinc_r <= q_scale(s3_prod_i_r);
      s4_d_r    <= q_scale(s3_prod_d_r);
      s4_ctl_r  <= s3_ctl_r;
    end
  end

  assign s4_valid = s4_valid_r;
  assign s4_p     = s4_p_r;
  assign s4_iinc  = s4_iinc_r;
  assign s4_d     = s4_d_r;
  assign s4_ctl   = s4_ctl_r;

endmodule

`default_nettype wire

// ----- rtl/pidc_acc.sv -----
// ---------------------------------------------------------------------------
// pidc_acc
// integral and derivative state, output sum, clamps and result register
// ---------------------------------------------------------------------------
`default_nettype none

module pidc_acc
  import pidc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          s4_valid,
  output logic                               s4_ready_dn,
  input  wire logic signed [VALUE_WIDTH-1:0] s4_p,
  input  wire logic signed [VALUE_WIDTH-1:0] s4_iinc,
  input  wire logic signed [VALUE_WIDTH-1:0] s4_d,
  input  wire ctl_t                          s4_ctl,
  input  wire logic signed [VALUE_WIDTH-1:0] drive_min,
  input  wire logic [VALUE_WIDTH-2:0]        drive_max,
  input  wire logic signed [VALUE_WIDTH-1:0] plant_bias,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0]      out_drive,
  output logic signed [VALUE_WIDTH-1:0]      out_p,
  output logic signed [VALUE_WIDTH-1:0]      out_i,
  output logic signed [VALUE_WIDTH-1:0]      out_d
);

  localparam int W = VALUE_WIDTH;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] add_sat(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? VMIN : VMAX;
    end
    return s[W-1:0];
  endfunction

  logic signed [W-1:0] integ_r, integ_nxt;
  logic signed [W-1:0] deriv_r, deriv_nxt;
  logic                below_min_r, below_min_nxt;
  logic                out_valid_r;
  logic signed [W-1:0] drive_r, drive_nxt;
  logic signed [W-1:0] p_r, i_r, d_r;

  logic signed [W-1:0] dmax_s, dmax_neg, acc_sum, y_sum;
  logic                out_ready, take;

  assign out_ready   = !out_valid_r || !out_stall;
  assign s4_ready_dn = out_ready;
  assign take        = s4_valid && out_ready;

  always_comb begin
    dmax_s   = signed'({1'b0, drive_max});
    dmax_neg = -dmax_s;
    acc_sum  = add_sat(integ_r, s4_iinc);
    integ_nxt = integ_r;
    if (s4_ctl.integ_ok && !below_min_r) begin
      if (acc_sum > dmax_s) begin
        integ_nxt = dmax_s;
      end else if (acc_sum < dmax_neg) begin
        integ_nxt = dmax_neg;
      end else begin
        integ_nxt = acc_sum;
      end
    end
    deriv_nxt = s4_ctl.ring_full ? s4_d : deriv_r;
    y_sum = add_sat(add_sat(add_sat(s4_p, integ_nxt), deriv_nxt), plant_bias);
    below_min_nxt = (y_sum < drive_min);
    if (y_sum > dmax_s) begin
      drive_nxt = dmax_s;
    end else if (y_sum < drive_min) begin
      drive_nxt = drive_min;
    end else begin
      drive_nxt = y_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      deriv_r     <= '0;
      below_min_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= s4_valid;
      end
      if (take) begin
        integ_r     <= integ_nxt;
        deriv_r     <= deriv_nxt;
        below_min_r <= below_min_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      drive_r <= drive_nxt;
      p_r     <= s4_p;
      i_r     <= integ_nxt;
      d_r     <= deriv_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = drive_r;
  assign out_p     = p_r;
  assign out_i     = i_r;
  assign out_d     = d_r;

endmodule

`default_nettype wire

// ----- rtl/pid_conditional_integral_delayed_deriv_core.sv -----
// ---------------------------------------------------------------------------
// pid_conditional_integral_delayed_deriv_core
// pid controller with conditional integration and delayed-sample derivative
// ---------------------------------------------------------------------------
// Takes one transaction per clock while the output is not stalled and
// returns one result per transaction through five register stages. The
// integral, derivative-hold and below-min state is computed and registered
// in the last stage, which keeps consecutive samples back to back at one
// per clock when the output is not stalled. The sample history ring is a
// memory with a fill count, so no clearing pass is run after reset.
// Configuration writes are always ready and should only be issued while no
// transaction is in flight.
`default_nettype none

module pid_conditional_integral_delayed_deriv_core
  import pidc_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [VALUE_WIDTH-1:0]        cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [VALUE_WIDTH-1:0] in_sample_value,
  input  wire logic                          in_integ_enable,
  input  wire logic signed [VALUE_WIDTH-1:0] in_perturb_offset,
  input  wire logic                          in_history_strobe,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0]      out_drive_out,
  output logic signed [VALUE_WIDTH-1:0]      out_p_term,
  output logic signed [VALUE_WIDTH-1:0]      out_i_term,
  output logic signed [VALUE_WIDTH-1:0]      out_d_term
);

  localparam int W = VALUE_WIDTH;

  logic signed [W-1:0] target_value_r, gain_prop_r, gain_integ_r, gain_deriv_r;
  logic signed [W-1:0] drive_min_r, plant_bias_r;
  logic [W-2:0]        drive_max_r, integ_window_r;

  logic                in_ready;
  logic                s2_valid, s2_ready_dn;
  logic signed [W-1:0] s2_err, s2_perr, s2_diff;
  ctl_t                s2_ctl;
  logic                s4_valid, s4_ready_dn;
  logic signed [W-1:0] s4_p, s4_iinc, s4_d;
  ctl_t                s4_ctl;

  assign cfg_ready = 1'b1;
  assign in_stall  = !in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_value_r <= '0;
      gain_prop_r    <= '0;
      gain_integ_r   <= '0;
      gain_deriv_r   <= '0;
      drive_min_r    <= {1'b1, {(W-1){1'b0}}};
      drive_max_r    <= '1;
      integ_window_r <= '0;
      plant_bias_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TARGET_VALUE: target_value_r <= cfg_data;
        REG_GAIN_PROP:    gain_prop_r    <= cfg_data;
        REG_GAIN_INTEG:   gain_integ_r   <= cfg_data;
        REG_GAIN_DERIV:   gain_deriv_r   <= cfg_data;
        REG_DRIVE_MIN:    drive_min_r    <= cfg_data;
        REG_DRIVE_MAX:    drive_max_r    <= cfg_data[W-2:0];
        REG_INTEG_WINDOW: integ_window_r <= cfg_data[W-2:0];
        REG_PLANT_BIAS:   plant_bias_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  pidc_front #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample_value),
    .in_enable    (in_integ_enable),
    .in_offset    (in_perturb_offset),
    .in_strobe    (in_history_strobe),
    .target_value (target_value_r),
    .integ_window (integ_window_r),
    .s2_valid     (s2_valid),
    .s2_ready_dn  (s2_ready_dn),
    .s2_err       (s2_err),
    .s2_perr      (s2_perr),
    .s2_diff      (s2_diff),
    .s2_ctl       (s2_ctl)
  );

  pidc_mul #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mul (
    .clk         (clk),
    .rst_n       (rst_n),
    .s2_valid    (s2_valid),
    .s2_ready_dn (s2_ready_dn),
    .s2_err      (s2_err),
    .s2_perr     (s2_perr),
    .s2_diff     (s2_diff),
    .s2_ctl      (s2_ctl),
    .gain_prop   (gain_prop_r),
    .gain_integ  (gain_integ_r),
    .gain_deriv  (gain_deriv_r),
    .s4_valid    (s4_valid),
    .s4_ready_dn (s4_ready_dn),
    .s4_p        (s4_p),
    .s4_iinc     (s4_iinc),
    .s4_d        (s4_d),
    .s4_ctl      (s4_ctl)
  );

  pidc_acc #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .s4_valid    (s4_valid),
    .s4_ready_dn (s4_ready_dn),
    .s4_p        (s4_p),
    .s4_iinc     (s4_iinc),
    .s4_d        (s4_d),
    .s4_ctl      (s4_ctl),
    .drive_min   (drive_min_r),
    .drive_max   (drive_max_r),
    .plant_bias  (plant_bias_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_drive   (out_drive_out),
    .out_p       (out_p_term),
    .out_i       (out_i_term),
    .out_d       (out_d_term)
  );

endmodule

`default_nettype wire
